>>> design/ntm_pkg.sv
// ----------------------------------------------------------------------------
// ntm_pkg: shared types and constants for the nearest timestamp matcher
// Table geometry, field widths, operation and status codes, and the
// command / status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ntm_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int OP_W     = 3;
   localparam int TS_W     = 63;
   localparam int WIDE_W   = TS_W + 1;
   localparam int THR_W    = 32;
   localparam int STATUS_W = 4;
   localparam int ENTRY_W  = 12;
   localparam int ORD_W    = 32;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd5000000;

   typedef logic [WIDE_W-1:0] wide_type;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND  = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_RUN     = 3'd2,
      OP_MATCH   = 3'd3,
      OP_NEAREST = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED = 4'd0,
      ST_FULL     = 4'd1,
      ST_CLEARED  = 4'd2,
      ST_RUN      = 4'd3,
      ST_MATCHED  = 4'd4,
      ST_BEFORE   = 4'd5,
      ST_AFTER    = 4'd6,
      ST_FAR      = 4'd7,
      ST_EMPTY    = 4'd8,
      ST_NEAREST  = 4'd9
   } status_type;

   // memory read address source
   typedef enum logic [2:0] {
      RD_FIRST = 3'd0,
      RD_LAST  = 3'd1,
      RD_MID0  = 3'd2,
      RD_MID   = 3'd3,
      RD_LO_M1 = 3'd4,
      RD_LO    = 3'd5
   } rd_sel_type;

   // source of the pending result's index and distance
   typedef enum logic [2:0] {
      SRC_ZERO   = 3'd0,
      SRC_APPEND = 3'd1,
      SRC_FIRST  = 3'd2,
      SRC_LAST   = 3'd3,
      SRC_CHOSEN = 3'd4
   } pend_src_type;

   typedef struct packed {
      logic         accept;
      logic         do_append;
      logic         do_clear;
      logic         do_run;
      rd_sel_type   rd_sel;
      logic         search_init;
      logic         search_step;
      logic         keep_first;
      logic         keep_cand;
      logic         choose;
      logic         pend_load;
      status_type   pend_status;
      pend_src_type pend_src;
      logic         push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic table_empty;
      logic table_full;
      logic before_range;
      logic after_range;
      logic search_done;
      logic too_far;
      logic out_free;
   } dp_status_type;

   // absolute distance between two timestamps
   function automatic logic [TS_W-1:0] abs_dist(input logic [TS_W-1:0] a,
                                                 input logic [TS_W-1:0] b);
      logic [TS_W-1:0] res;
      res = (a >= b) ? (a - b) : (b - a);
      return res;
   endfunction

endpackage

>>> design/ntm_req_if.sv
// ----------------------------------------------------------------------------
// ntm_req_if: request channel
// Carries one operation and its timestamp per transfer.
// ----------------------------------------------------------------------------
interface ntm_req_if import ntm_pkg::*;;
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] operation;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output operation, output timestamp, input ready);
   modport sink (input valid, input operation, input timestamp, output ready);
   modport monitor (input valid, input operation, input timestamp, input ready);
endinterface

>>> design/ntm_rsp_if.sv
// ----------------------------------------------------------------------------
// ntm_rsp_if: result channel
// Carries one result item per transfer.
// ----------------------------------------------------------------------------
interface ntm_rsp_if import ntm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  entry_index;
   logic [TS_W-1:0]     time_difference;
   logic [ORD_W-1:0]    match_ordinal;

   modport source (output valid, output status, output entry_index,
                   output time_difference, output match_ordinal, input ready);
   modport sink (input valid, input status, input entry_index,
                 input time_difference, input match_ordinal, output ready);
   modport monitor (input valid, input status, input entry_index,
                    input time_difference, input match_ordinal, input ready);
endinterface

>>> design/ntm_csr_if.sv
// ----------------------------------------------------------------------------
// ntm_csr_if: threshold write channel
// Carries the match threshold write data per transfer.
// ----------------------------------------------------------------------------
interface ntm_csr_if import ntm_pkg::*;;
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

>>> design/ntm_datapath.sv
// ----------------------------------------------------------------------------
// ntm_datapath: table memory, search registers and result registers
// Executes the controller's commands: appends, range checks, one halving
// step of the lower-bound search per cycle, candidate pick and result output.
// ----------------------------------------------------------------------------
module ntm_datapath import ntm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       st,
   input  logic [TS_W-1:0]     req_timestamp,
   input  logic                csr_valid,
   input  logic [THR_W-1:0]    csr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ENTRY_W-1:0]  rsp_entry_index,
   output logic [TS_W-1:0]     rsp_time_difference,
   output logic [ORD_W-1:0]    rsp_match_ordinal
);

   // table memory
   logic [TS_W-1:0] mem [TABLE_DEPTH];
   logic [TS_W-1:0] rdata_ff;
   logic [IDX_W-1:0] rd_addr;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ORD_W-1:0] matches_ff, matches_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [TS_W-1:0]  ts_ff, first_ff, cand_dist_ff, chosen_diff_ff, pend_diff_ff;
   logic [CNT_W-1:0] lo_ff, hi_ff, mid_ff;
   logic [IDX_W-1:0] chosen_idx_ff, pend_idx_ff;
   status_type       pend_status_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ENTRY_W-1:0]  rsp_idx_ff;
   logic [TS_W-1:0]     rsp_diff_ff;
   logic [ORD_W-1:0]    rsp_ord_ff;

   // search step and helpers
   logic             below;
   logic [CNT_W-1:0] lo_in, hi_in, mid_in, mid0, last_cnt, lo_m1;
   logic [TS_W-1:0]  dist_rd, dist_first;
   logic             hi_closer;
   logic [IDX_W-1:0] choose_idx;
   logic [TS_W-1:0]  choose_diff;
   logic [IDX_W-1:0] src_idx;
   logic [TS_W-1:0]  src_diff;
   logic [ORD_W-1:0] matches_push;

   assign below    = rdata_ff < ts_ff;
   assign lo_in    = below ? (mid_ff + 1'b1) : lo_ff;
   assign hi_in    = below ? hi_ff : mid_ff;
   assign mid_in   = lo_in + ((hi_in - lo_in) >> 1);
   assign mid0     = count_ff >> 1;
   assign last_cnt = count_ff - 1'b1;
   assign lo_m1    = lo_ff - 1'b1;

   assign dist_rd    = abs_dist(rdata_ff, ts_ff);
   assign dist_first = abs_dist(first_ff, ts_ff);
   assign hi_closer  = dist_rd < cand_dist_ff;

   // status toward the controller
   assign st.table_empty  = (count_ff == '0);
   assign st.table_full   = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign st.before_range = (wide_type'(ts_ff) + wide_type'(thr_ff)) < wide_type'(first_ff);
   assign st.after_range  = wide_type'(ts_ff) > (wide_type'(rdata_ff) + wide_type'(thr_ff));
   assign st.search_done  = !(lo_in < hi_in);
   assign st.too_far      = chosen_diff_ff > TS_W'(thr_ff);
   assign st.out_free     = !rsp_valid_ff || rsp_ready;

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = last_cnt[IDX_W-1:0];
         RD_MID0:  rd_addr = mid0[IDX_W-1:0];
         RD_MID:   rd_addr = mid_in[IDX_W-1:0];
         RD_LO_M1: rd_addr = lo_m1[IDX_W-1:0];
         RD_LO:    rd_addr = lo_ff[IDX_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.do_append) begin
         mem[count_ff[IDX_W-1:0]] <= req_timestamp;
      end
      rdata_ff <= mem[rd_addr];
   end

   // pick between the lower-bound entry and the one before it
   always_comb begin
      if (lo_ff >= count_ff) begin
         choose_idx  = lo_m1[IDX_W-1:0];
         choose_diff = cand_dist_ff;
      end else if (lo_ff == '0) begin
         choose_idx  = '0;
         choose_diff = dist_rd;
      end else if (hi_closer) begin
         choose_idx  = lo_ff[IDX_W-1:0];
         choose_diff = dist_rd;
      end else begin
         choose_idx  = lo_m1[IDX_W-1:0];
         choose_diff = cand_dist_ff;
      end
   end

   // pending result source
   always_comb begin
      case (cmd.pend_src)
         SRC_ZERO: begin
            src_idx  = '0;
            src_diff = '0;
         end
         SRC_APPEND: begin
            src_idx  = count_ff[IDX_W-1:0];
            src_diff = '0;
         end
         SRC_FIRST: begin
            src_idx  = '0;
            src_diff = dist_first;
         end
         SRC_LAST: begin
            src_idx  = last_cnt[IDX_W-1:0];
            src_diff = dist_rd;
         end
         SRC_CHOSEN: begin
            src_idx  = chosen_idx_ff;
            src_diff = chosen_diff_ff;
         end
         default: begin
            src_idx  = '0;
            src_diff = '0;
         end
      endcase
   end

   // run counter after this result, saturating
   assign matches_push = (pend_status_ff == ST_MATCHED && !(&matches_ff))
                         ? matches_ff + 1'b1 : matches_ff;

   // control state next values
   always_comb begin
      count_in     = count_ff;
      matches_in   = matches_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.do_append) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.do_clear) begin
         count_in = '0;
      end
      if (cmd.do_run) begin
         matches_in = '0;
      end
      if (csr_valid) begin
         thr_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.push) begin
         matches_in   = matches_push;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         matches_ff   <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         matches_ff   <= matches_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ts_ff <= req_timestamp;
      end
      if (cmd.keep_first) begin
         first_ff <= rdata_ff;
      end
      if (cmd.search_init) begin
         lo_ff  <= '0;
         hi_ff  <= count_ff;
         mid_ff <= mid0;
      end else if (cmd.search_step) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.keep_cand) begin
         cand_dist_ff <= dist_rd;
      end
      if (cmd.choose) begin
         chosen_idx_ff  <= choose_idx;
         chosen_diff_ff <= choose_diff;
      end
      if (cmd.pend_load) begin
         pend_status_ff <= cmd.pend_status;
         pend_idx_ff    <= src_idx;
         pend_diff_ff   <= src_diff;
      end
      if (cmd.push) begin
         rsp_status_ff <= pend_status_ff;
         rsp_idx_ff    <= ENTRY_W'(pend_idx_ff);
         rsp_diff_ff   <= pend_diff_ff;
         rsp_ord_ff    <= (pend_status_ff == ST_APPENDED || pend_status_ff == ST_FULL)
                          ? '0 : matches_push;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_index     = rsp_idx_ff;
   assign rsp_time_difference = rsp_diff_ff;
   assign rsp_match_ordinal   = rsp_ord_ff;

endmodule

>>> design/ntm_ctrl.sv
// ----------------------------------------------------------------------------
// ntm_ctrl: operation sequencer
// Decodes each accepted request and walks the datapath through range
// checks, the halving search, the candidate pick and the result handoff.
// ----------------------------------------------------------------------------
module ntm_ctrl import ntm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_operation,
   output logic            req_ready,
   input  dp_status_type   st,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_FIRST  = 9'b000000010,
      S_LAST   = 9'b000000100,
      S_SEARCH = 9'b000001000,
      S_PICK_A = 9'b000010000,
      S_PICK_B = 9'b000100000,
      S_PICK_C = 9'b001000000,
      S_DECIDE = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      gated_ff, gated_in;
   logic      req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_ready && req_valid;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      gated_in        = gated_ff;
      cmd             = '0;
      cmd.rd_sel      = RD_FIRST;
      cmd.pend_status = ST_EMPTY;
      cmd.pend_src    = SRC_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.accept = 1'b1;
               case (op_type'(req_operation))
                  OP_APPEND: begin
                     cmd.pend_load = 1'b1;
                     if (st.table_full) begin
                        cmd.pend_status = ST_FULL;
                     end else begin
                        cmd.do_append   = 1'b1;
                        cmd.pend_status = ST_APPENDED;
                        cmd.pend_src    = SRC_APPEND;
                     end
                     state_in = S_DONE;
                  end
                  OP_CLEAR: begin
                     cmd.do_clear    = 1'b1;
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = ST_CLEARED;
                     state_in        = S_DONE;
                  end
                  OP_RUN: begin
                     cmd.do_run      = 1'b1;
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = ST_RUN;
                     state_in        = S_DONE;
                  end
                  OP_MATCH: begin
                     gated_in = 1'b1;
                     if (st.table_empty) begin
                        cmd.pend_load = 1'b1;
                        state_in      = S_DONE;
                     end else begin
                        cmd.rd_sel = RD_FIRST;
                        state_in   = S_FIRST;
                     end
                  end
                  OP_NEAREST: begin
                     gated_in = 1'b0;
                     if (st.table_empty) begin
                        cmd.pend_load = 1'b1;
                        state_in      = S_DONE;
                     end else begin
                        cmd.search_init = 1'b1;
                        cmd.rd_sel      = RD_MID0;
                        state_in        = S_SEARCH;
                     end
                  end
                  default: begin
                     // undefined codes are dropped without a result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FIRST: begin
            cmd.keep_first = 1'b1;
            cmd.rd_sel     = RD_LAST;
            state_in       = S_LAST;
         end
         S_LAST: begin
            if (st.before_range) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = ST_BEFORE;
               cmd.pend_src    = SRC_FIRST;
               state_in        = S_DONE;
            end else if (st.after_range) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = ST_AFTER;
               cmd.pend_src    = SRC_LAST;
               state_in        = S_DONE;
            end else begin
               cmd.search_init = 1'b1;
               cmd.rd_sel      = RD_MID0;
               state_in        = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            cmd.rd_sel      = RD_MID;
            if (st.search_done) begin
               state_in = S_PICK_A;
            end
         end
         S_PICK_A: begin
            cmd.rd_sel = RD_LO_M1;
            state_in   = S_PICK_B;
         end
         S_PICK_B: begin
            cmd.keep_cand = 1'b1;
            cmd.rd_sel    = RD_LO;
            state_in      = S_PICK_C;
         end
         S_PICK_C: begin
            cmd.choose = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.pend_load = 1'b1;
            cmd.pend_src  = SRC_CHOSEN;
            if (!gated_ff) begin
               cmd.pend_status = ST_NEAREST;
            end else if (st.too_far) begin
               cmd.pend_status = ST_FAR;
            end else begin
               cmd.pend_status = ST_MATCHED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gated_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gated_ff <= gated_in;
      end
   end

endmodule

>>> design/nearest_timestamp_matcher_core.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_core: sorted timestamp table with nearest match
// Holds up to TABLE_DEPTH reference timestamps and answers gated and plain
// nearest-entry queries by binary search over the table memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one operation per transfer (append, clear, start run, gated
//             match, nearest) with its timestamp.
//   rsp_ch  : one result per defined operation; undefined codes give none.
//   csr_ch  : writes the match threshold; always ready, write only while
//             the block is idle.
// Timing:
//   append, clear, start run and empty-table queries go straight to the
//   result handoff. A nearest query runs the halving search and the pick;
//   a gated match first checks the range against the first and last entries
//   and, if it passes, does the same. The search takes about log2(entry
//   count) + 1 halving steps (13 for a full 4096-entry table), one step per
//   cycle, set by the single memory read port. One item is in work at a
//   time; the next request is taken as soon as the sequencer is back in idle.
// Reset: the table is emptied, the run counter cleared, the threshold set
//   to 5000000 ns. Table contents are not cleared and no sweep is needed.
// Stall: a finished result waits in the output register; the next request
//   is still accepted and worked on, and only its own handoff waits.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_core import ntm_pkg::*; (
   input logic       clock,
   input logic       reset,
   ntm_req_if.sink   req_ch,
   ntm_rsp_if.source rsp_ch,
   ntm_csr_if.sink   csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   // threshold writes complete in the cycle they are offered
   assign csr_ch.ready = 1'b1;

   // sequencer
   ntm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .st            (st),
      .cmd           (cmd)
   );

   // table and result datapath
   ntm_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_timestamp       (req_ch.timestamp),
      .csr_valid           (csr_ch.valid),
      .csr_data            (csr_ch.data),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_status          (rsp_ch.status),
      .rsp_entry_index     (rsp_ch.entry_index),
      .rsp_time_difference (rsp_ch.time_difference),
      .rsp_match_ordinal   (rsp_ch.match_ordinal)
   );

endmodule

>>> design/ntm_checker.sv
// ----------------------------------------------------------------------------
// ntm_checker: port-level checks for the nearest timestamp matcher
// Watches the result channel and flags illegal result items.
// ----------------------------------------------------------------------------
module ntm_checker import ntm_pkg::*; (
   input logic       clock,
   input logic       reset,
   ntm_rsp_if.source rsp_ch
);

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.status) && $stable(rsp_ch.time_difference)
         && $stable(rsp_ch.entry_index) && $stable(rsp_ch.match_ordinal))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // status codes stay in the defined range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.status <= ST_NEAREST)
      else $error("undefined result status");

   // table-building and control results carry no distance
   a_zero_diff: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_APPENDED || rsp_ch.status == ST_FULL
                       || rsp_ch.status == ST_RUN || rsp_ch.status == ST_EMPTY
                       || rsp_ch.status == ST_CLEARED)
      |-> rsp_ch.time_difference == '0)
      else $error("nonzero distance on a non-query result");

   // an append result carries no ordinal, a run start resets it
   a_zero_ordinal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_APPENDED || rsp_ch.status == ST_FULL
                       || rsp_ch.status == ST_RUN)
      |-> rsp_ch.match_ordinal == '0)
      else $error("nonzero ordinal on append or run start");

endmodule

bind nearest_timestamp_matcher_core ntm_checker u_ntm_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);

>>> tb/nearest_timestamp_matcher_core_test.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_core_test: self-checking bench for the matcher
// Drives appends, clears, run starts, gated matches and nearest queries
// through the request channel and updates the match threshold between
// phases. A local model of the table and the run counter predicts every
// result. Each result is checked field by field, in order, against that
// prediction, with random idling on both channels.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_core_test import ntm_pkg::*;;

   localparam logic [TS_W-1:0] TS_MAX      = {TS_W{1'b1}};
   localparam int unsigned     SETTLE_CYCLES = 32;
   localparam int unsigned     CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      status_type         status;
      logic [ENTRY_W-1:0] entry_index;
      logic [TS_W-1:0]    time_difference;
      logic [ORD_W-1:0]   match_ordinal;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ntm_req_if req_bus ();
   ntm_rsp_if rsp_bus ();
   ntm_csr_if csr_bus ();

   nearest_timestamp_matcher_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // model of the table, the run counter and the threshold
   logic [TS_W-1:0]  ref_table [TABLE_DEPTH];
   int unsigned      table_count = 0;
   logic [ORD_W-1:0] run_matches = '0;
   logic [THR_W-1:0] threshold   = THRESHOLD_RESET;

   match_result_type pending_results [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [TS_W-1:0] abs_gap(input logic [TS_W-1:0] a,
                                              input logic [TS_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // lower-bound halving search, then the closer of the two neighbors
   function automatic int unsigned nearest_slot(input logic [TS_W-1:0] ts);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = table_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (ref_table[mid] < ts) lo = mid + 1;
         else hi = mid;
      end
      if (lo >= table_count) return table_count - 1;
      if (lo == 0) return 0;
      if (abs_gap(ref_table[lo], ts) < abs_gap(ref_table[lo - 1], ts)) return lo;
      return lo - 1;
   endfunction

   // update the model for one accepted request and queue its result
   function automatic void predict_item(input logic [OP_W-1:0] op,
                                        input logic [TS_W-1:0] ts);
      match_result_type r;
      logic [63:0]   wide_ts;
      logic [63:0]   wide_thr;
      int unsigned   pick;
      logic [TS_W-1:0] gap;
      r.status          = ST_APPENDED;
      r.entry_index     = '0;
      r.time_difference = '0;
      r.match_ordinal   = run_matches;
      wide_ts  = {1'b0, ts};
      wide_thr = {32'b0, threshold};
      case (op)
         OP_APPEND: begin
            r.match_ordinal = '0;
            if (table_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               ref_table[table_count] = ts;
               r.entry_index = ENTRY_W'(table_count);
               table_count++;
            end
         end
         OP_CLEAR: begin
            table_count = 0;
            r.status = ST_CLEARED;
         end
         OP_RUN: begin
            run_matches = '0;
            r.status = ST_RUN;
            r.match_ordinal = '0;
         end
         OP_MATCH, OP_NEAREST: begin
            if (table_count == 0) begin
               r.status = ST_EMPTY;
            end else if (op == OP_MATCH && wide_ts + wide_thr < {1'b0, ref_table[0]}) begin
               r.status = ST_BEFORE;
               r.time_difference = abs_gap(ref_table[0], ts);
            end else if (op == OP_MATCH &&
                         wide_ts > {1'b0, ref_table[table_count - 1]} + wide_thr) begin
               r.status = ST_AFTER;
               r.entry_index = ENTRY_W'(table_count - 1);
               r.time_difference = abs_gap(ref_table[table_count - 1], ts);
            end else begin
               pick = nearest_slot(ts);
               gap  = abs_gap(ref_table[pick], ts);
               r.entry_index = ENTRY_W'(pick);
               r.time_difference = gap;
               if (op == OP_NEAREST) begin
                  r.status = ST_NEAREST;
               end else if ({1'b0, gap} > wide_thr) begin
                  r.status = ST_FAR;
               end else begin
                  // counter saturates
                  if (run_matches != '1) run_matches++;
                  r.status = ST_MATCHED;
                  r.match_ordinal = run_matches;
               end
            end
         end
         default: return;
      endcase
      pending_results = {pending_results, r};
   endfunction

   // result checker
   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: expected no result, actual status %0d index %0d diff %0d ord %0d",
                     $time, rsp_bus.status, rsp_bus.entry_index, rsp_bus.time_difference,
                     rsp_bus.match_ordinal);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.entry_index !== want.entry_index) begin
               $display("%0t: entry_index expected %0d actual %0d",
                        $time, want.entry_index, rsp_bus.entry_index);
               error_count++;
            end
            if (rsp_bus.time_difference !== want.time_difference) begin
               $display("%0t: time_difference expected %0d actual %0d",
                        $time, want.time_difference, rsp_bus.time_difference);
               error_count++;
            end
            if (rsp_bus.match_ordinal !== want.match_ordinal) begin
               $display("%0t: match_ordinal expected %0d actual %0d",
                        $time, want.match_ordinal, rsp_bus.match_ordinal);
               error_count++;
            end
         end
      end
   end

   // one request transfer; entered and left at a falling edge, valid left high
   task automatic issue_request(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
         req_bus.valid     <= 1'b1;
         req_bus.operation <= op;
         req_bus.timestamp <= ts;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         predict_item(op, ts);
         @(negedge clock);
      end
   endtask

   // threshold write once the block has drained
   task automatic write_threshold(input logic [THR_W-1:0] value);
      begin
         req_bus.valid <= 1'b0;
         while (pending_results.size() != 0) @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
         csr_bus.valid <= 1'b1;
         csr_bus.data  <= value;
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         threshold = value;
         @(negedge clock);
         csr_bus.valid <= 1'b0;
      end
   endtask

   function automatic logic [TS_W-1:0] rand_stamp();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TS_W-1:0];
   endfunction

   // query near an anchor, offsets spread around the threshold
   function automatic logic [TS_W-1:0] query_near(input logic [TS_W-1:0] anchor);
      logic [63:0] off;
      logic [63:0] v;
      case ($urandom_range(5))
         0: off = '0;
         1: off = {32'b0, 32'($urandom_range(threshold))};
         2: off = {32'b0, threshold};
         3: off = {32'b0, threshold} + 64'd1;
         4: off = {32'b0, threshold} + 64'($urandom_range(1000));
         default: off = {$urandom, $urandom} >> $urandom_range(63, 20);
      endcase
      if ($urandom_range(1)) v = {1'b0, anchor} + off;
      else v = (off > {1'b0, anchor}) ? 64'd0 : {1'b0, anchor} - off;
      if (v > {1'b0, TS_MAX}) v = {1'b0, TS_MAX};
      return v[TS_W-1:0];
   endfunction

   function automatic logic [TS_W-1:0] pick_query();
      int unsigned i;
      logic [63:0] mid;
      if (table_count == 0 || $urandom_range(15) == 0) return rand_stamp();
      i = $urandom_range(table_count - 1);
      // midpoint between neighbors gives ties
      if (i + 1 < table_count && $urandom_range(4) == 0) begin
         mid = ({1'b0, ref_table[i]} + {1'b0, ref_table[i + 1]}) >> 1;
         return mid[TS_W-1:0];
      end
      return query_near(ref_table[i]);
   endfunction

   function automatic logic [63:0] next_spacing();
      case ($urandom_range(4))
         0: return '0;
         1: return 64'($urandom_range(threshold));
         2: return {32'b0, threshold} * 2;
         3: return 64'($urandom_range(100));
         default: return {32'b0, $urandom};
      endcase
   endfunction

   // queries, ignored codes, a run start and a clear on an empty table
   task automatic test_empty_table();
      begin
         issue_request(OP_NEAREST, '0);
         issue_request(OP_MATCH, TS_MAX);
         issue_request(3'd5, rand_stamp());
         issue_request(3'd6, rand_stamp());
         issue_request(3'd7, rand_stamp());
         issue_request(OP_RUN, '0);
         issue_request(OP_CLEAR, TS_MAX);
      end
   endtask

   // range rejects, ties, duplicates, unsorted appends, threshold extremes
   task automatic test_special_cases();
      begin
         issue_request(OP_APPEND, 63'd20_000_000);
         issue_request(OP_APPEND, 63'd21_000_000);
         issue_request(OP_APPEND, 63'd21_000_000);
         issue_request(OP_APPEND, 63'd40_000_000);
         issue_request(OP_RUN, '0);
         issue_request(OP_MATCH, 63'd20_000_000);
         issue_request(OP_MATCH, 63'd20_500_000);
         issue_request(OP_MATCH, 63'd21_000_000);
         issue_request(OP_MATCH, 63'd1_000_000);
         issue_request(OP_MATCH, 63'd50_000_000);
         issue_request(OP_MATCH, 63'd30_500_000);
         issue_request(OP_MATCH, 63'd45_000_000);
         issue_request(OP_NEAREST, '0);
         issue_request(OP_NEAREST, TS_MAX);
         issue_request(OP_APPEND, '0);
         issue_request(OP_NEAREST, 63'd10);
         issue_request(OP_APPEND, TS_MAX);
         write_threshold('0);
         issue_request(OP_MATCH, 63'd20_000_000);
         issue_request(OP_MATCH, 63'd20_000_001);
         write_threshold('1);
         issue_request(OP_MATCH, '0);
         issue_request(OP_MATCH, TS_MAX);
         issue_request(OP_CLEAR, '0);
         issue_request(OP_MATCH, 63'd20_000_000);
      end
   endtask

   // fill to capacity, overflow append, searches over the full table
   task automatic test_full_table();
      logic [TS_W-1:0] stamp;
      int unsigned k;
      begin
         write_threshold(32'($urandom_range(2000)));
         issue_request(OP_CLEAR, '0);
         stamp = rand_stamp() >> 2;
         for (k = 0; k < TABLE_DEPTH; k++) begin
            issue_request(OP_APPEND, stamp);
            stamp = stamp + 63'($urandom_range(1000));
         end
         issue_request(OP_APPEND, stamp);
         issue_request(OP_RUN, '0);
         for (k = 0; k < 8; k++) issue_request(OP_MATCH, pick_query());
         for (k = 0; k < 4; k++) issue_request(OP_NEAREST, pick_query());
         issue_request(OP_MATCH, ref_table[TABLE_DEPTH - 1]);
         issue_request(OP_NEAREST, TS_MAX);
         issue_request(OP_CLEAR, '0);
      end
   endtask

   // mostly sorted tables with queries around them, some noise
   task automatic test_random_traffic(input int unsigned item_goal);
      int unsigned sent;
      int unsigned n_app;
      int unsigned n_query;
      int unsigned k;
      int unsigned code;
      logic [TS_W-1:0] stamp;
      begin
         sent = 0;
         while (sent < item_goal) begin
            if ($urandom_range(99) < 80) begin
               issue_request(OP_CLEAR, rand_stamp());
               sent++;
               n_app = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
               stamp = rand_stamp() >> $urandom_range(40, 1);
               for (k = 0; k < n_app; k++) begin
                  issue_request(OP_APPEND, stamp);
                  sent++;
                  stamp = stamp + TS_W'(next_spacing());
               end
               if ($urandom_range(1)) begin
                  issue_request(OP_RUN, rand_stamp());
                  sent++;
               end
               n_query = $urandom_range(20, 1);
               for (k = 0; k < n_query; k++) begin
                  issue_request(($urandom_range(3) == 0) ? OP_NEAREST : OP_MATCH, pick_query());
                  sent++;
               end
            end else begin
               // noise: any code, unsorted appends
               code = $urandom_range(7);
               issue_request(OP_W'(code), $urandom_range(1) ? rand_stamp() : pick_query());
               if (code <= OP_NEAREST) sent++;
            end
         end
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = '0;
      req_bus.timestamp = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      send_idle_pct = 13;
      recv_idle_pct = 70;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_special_cases();

      write_threshold(THRESHOLD_RESET);
      test_random_traffic(250);
      write_threshold($urandom);
      test_random_traffic(250);

      send_idle_pct = 70;
      recv_idle_pct = 13;
      write_threshold('0);
      test_random_traffic(250);
      write_threshold('1);
      test_random_traffic(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_full_table();
      write_threshold(32'($urandom_range(1000)));
      test_random_traffic(250);
      write_threshold($urandom);
      test_random_traffic(250);

      // drain
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ntm_pkg.sv
design/ntm_req_if.sv
design/ntm_rsp_if.sv
design/ntm_csr_if.sv
design/ntm_datapath.sv
design/ntm_ctrl.sv
design/nearest_timestamp_matcher_core.sv
design/ntm_checker.sv
tb/nearest_timestamp_matcher_core_test.sv
